// ----- src/virtual_server_range_classifier_macros.svh -----
// Assertion macros used by the RTL of virtual_server_range_classifier.sv.
`ifndef VIRTUAL_SERVER_RANGE_CLASSIFIER_MACROS_SVH
`define VIRTUAL_SERVER_RANGE_CLASSIFIER_MACROS_SVH

// Check a property outside reset.
`define VSRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define VSRC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/vsrc_pkg.sv -----
package vsrc_pkg;

    localparam int unsigned ENTRIES = 64;
    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] FUNC_ADD  = 2'd0;
    localparam logic [1:0] FUNC_DEL  = 2'd1;
    localparam logic [1:0] FUNC_FIND = 2'd2;
    localparam logic [1:0] FUNC_NOP  = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

    localparam logic [2:0] KIND_LLB    = 3'd0;
    localparam logic [2:0] KIND_DOMAIN = 3'd5;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] ext_id;
        logic [2:0]  svc_kind;
        logic        is_v4;
        logic [63:0] addr_a_hi;
        logic [63:0] addr_a_lo;
        logic [63:0] addr_b_hi;
        logic [63:0] addr_b_lo;
        logic [15:0] port_a;
        logic [15:0] port_b;
        logic [15:0] pool_id;
        logic        skip_llb;
    } key_t;

    typedef struct packed {
        logic             vld;
        logic             free_fnd;
        logic [IDX_W-1:0] free_idx;
        logic             del_fnd;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [15:0]      hit_id;
        logic [15:0]      hit_pool;
        logic [2:0]       hit_kind;
    } tok_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } wr_t;

endpackage

// ----- src/vsrc_cell.sv -----
module vsrc_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [vsrc_pkg::IDX_W-1:0] cell_idx,
    input  logic [vsrc_pkg::IDX_W:0]   hw,
    input  vsrc_pkg::key_t            key,
    input  vsrc_pkg::wr_t             wr,
    input  vsrc_pkg::tok_t            tok_in,
    output vsrc_pkg::tok_t            tok_out
);

    logic        used_reg;
    logic        v4_reg;
    logic [15:0] id_reg;
    logic [2:0]  kind_reg;
    logic [15:0] pool_reg;
    logic [63:0] rlo_hi_reg;
    logic [63:0] rlo_lo_reg;
    logic [63:0] rhi_hi_reg;
    logic [63:0] rhi_lo_reg;
    logic [15:0] plo_reg;
    logic [15:0] phi_reg;
    vsrc_pkg::tok_t tok_reg;
    vsrc_pkg::tok_t tok_next;

    logic         below;
    logic         wr_here;
    logic         del_here;
    logic         eligible;
    logic         addr_ok;
    logic         port_ok;
    logic [63:0]  key4;
    logic [127:0] key6;
    logic [127:0] lo6;
    logic [127:0] hi6;

    assign below   = {1'b0, cell_idx} < hw;
    assign wr_here = wr.en && (wr.idx == cell_idx);
    assign del_here = tok_in.vld && (key.func == vsrc_pkg::FUNC_DEL) && below
                      && (id_reg == key.ext_id);

    assign key4 = {32'd0, key.addr_a_lo[31:0]};
    assign key6 = {key.addr_a_hi, key.addr_a_lo};
    assign lo6  = {rlo_hi_reg, rlo_lo_reg};
    assign hi6  = {rhi_hi_reg, rhi_lo_reg};

    always_comb
    begin
        if (key.is_v4)
        begin
            addr_ok = v4_reg && ((rlo_lo_reg == 64'd0)
                      || ((rlo_lo_reg <= key4) && (key4 <= rhi_lo_reg)));
        end
        else
        begin
            addr_ok = (lo6 == 128'd0) || ((lo6 <= key6) && (key6 <= hi6));
        end
        port_ok = (plo_reg == 16'd0) || (key.port_a == 16'd0)
                  || ((plo_reg <= key.port_a) && (key.port_a <= phi_reg));
        eligible = used_reg && (kind_reg != vsrc_pkg::KIND_DOMAIN)
                   && !(key.skip_llb && (kind_reg == vsrc_pkg::KIND_LLB));
    end

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.vld && below)
        begin
            if ((key.func == vsrc_pkg::FUNC_ADD) && !used_reg && !tok_in.free_fnd)
            begin
                tok_next.free_fnd = 1'b1;
                tok_next.free_idx = cell_idx;
            end
            if (del_here)
            begin
                tok_next.del_fnd = 1'b1;
            end
            if ((key.func == vsrc_pkg::FUNC_FIND) && !tok_in.hit && eligible
                && addr_ok && port_ok)
            begin
                tok_next.hit      = 1'b1;
                tok_next.hit_idx  = cell_idx;
                tok_next.hit_id   = id_reg;
                tok_next.hit_pool = pool_reg;
                tok_next.hit_kind = kind_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            v4_reg   <= 1'b0;
            id_reg   <= 16'd0;
            kind_reg <= 3'd0;
            tok_reg  <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (wr_here)
            begin
                used_reg <= 1'b1;
                v4_reg   <= key.is_v4;
                id_reg   <= key.ext_id;
                kind_reg <= key.svc_kind;
            end
            else if (del_here)
            begin
                used_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            pool_reg <= key.pool_id;
            plo_reg  <= key.port_a;
            phi_reg  <= key.port_b;
            if (key.is_v4)
            begin
                rlo_hi_reg <= 64'd0;
                rlo_lo_reg <= {32'd0, key.addr_a_lo[31:0]};
                rhi_hi_reg <= 64'd0;
                rhi_lo_reg <= {32'd0, key.addr_b_lo[31:0]};
            end
            else
            begin
                rlo_hi_reg <= key.addr_a_hi;
                rlo_lo_reg <= key.addr_a_lo;
                rhi_hi_reg <= key.addr_b_hi;
                rhi_lo_reg <= key.addr_b_lo;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- src/virtual_server_range_classifier.sv -----
// channel | direction | handshake        | payload
// in      | receive   | in_valid/in_stall | func .. skip_llb
// out     | send      | out_valid/out_stall | status .. hit_kind
//
// One item at a time: a token walks the row of entry cells, one cell a cycle.
// The row has one cell per entry (ENTRIES = 64).
// Reset marks every table entry unused and clears the high-water mark and all valid flags.
// A stalled result holds in the output register; the next item is taken
// only after the current result has left the scan.
module virtual_server_range_classifier (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [15:0] ext_id,
    input  logic [2:0]  svc_kind,
    input  logic        is_v4,
    input  logic [63:0] addr_a_hi,
    input  logic [63:0] addr_a_lo,
    input  logic [63:0] addr_b_hi,
    input  logic [63:0] addr_b_lo,
    input  logic [15:0] port_a,
    input  logic [15:0] port_b,
    input  logic [15:0] pool_id,
    input  logic        skip_llb,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        hit,
    output logic [5:0]  slot,
    output logic [15:0] hit_id,
    output logic [15:0] hit_pool,
    output logic [2:0]  hit_kind
);

`include "virtual_server_range_classifier_macros.svh"

    localparam int unsigned N = vsrc_pkg::ENTRIES;
    localparam int unsigned IW = vsrc_pkg::IDX_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    vsrc_pkg::key_t key_reg;
    vsrc_pkg::tok_t end_reg;
    logic           inj_reg;
    logic [IW:0]    hw_reg, hw_next;
    logic           out_valid_reg;
    logic [1:0]     status_reg, status_next;
    logic           hit_reg, hit_next;
    logic [5:0]     slot_reg, slot_next;
    logic [15:0]    hit_id_reg;
    logic [15:0]    hit_pool_reg;
    logic [2:0]     hit_kind_reg;

    vsrc_pkg::tok_t tok_link [0:N];
    vsrc_pkg::wr_t  wr;
    logic           accept;
    logic           finish;
    logic           hw_full;

    assign accept  = in_valid && state_reg[0];
    assign finish  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign hw_full = (hw_reg == (IW+1)'(N));

    always_comb
    begin
        tok_link[0]     = '0;
        tok_link[0].vld = inj_reg;
    end

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            vsrc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (IW'(g)),
                .hw       (hw_reg),
                .key      (key_reg),
                .wr       (wr),
                .tok_in   (tok_link[g]),
                .tok_out  (tok_link[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        wr          = '0;
        hw_next     = hw_reg;
        status_next = vsrc_pkg::STATUS_OK;
        hit_next    = 1'b0;
        slot_next   = 6'd0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tok_link[N].vld)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        case (key_reg.func)
            vsrc_pkg::FUNC_ADD:
            begin
                if (end_reg.free_fnd)
                begin
                    wr.en     = finish;
                    wr.idx    = end_reg.free_idx;
                    slot_next = 6'(end_reg.free_idx);
                end
                else if (hw_full)
                begin
                    status_next = vsrc_pkg::STATUS_FULL;
                end
                else
                begin
                    wr.en     = finish;
                    wr.idx    = hw_reg[IW-1:0];
                    slot_next = 6'(hw_reg[IW-1:0]);
                    if (finish)
                    begin
                        hw_next = hw_reg + 1'b1;
                    end
                end
            end
            vsrc_pkg::FUNC_DEL:
            begin
                status_next = end_reg.del_fnd ? vsrc_pkg::STATUS_OK
                                              : vsrc_pkg::STATUS_NOTFOUND;
            end
            vsrc_pkg::FUNC_FIND:
            begin
                hit_next = end_reg.hit;
                if (end_reg.hit)
                begin
                    slot_next = 6'(end_reg.hit_idx);
                end
            end
            default:
            begin
                status_next = vsrc_pkg::STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            inj_reg       <= 1'b0;
            hw_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            inj_reg   <= accept;
            hw_reg    <= hw_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg.func      <= func;
            key_reg.ext_id    <= ext_id;
            key_reg.svc_kind  <= svc_kind;
            key_reg.is_v4     <= is_v4;
            key_reg.addr_a_hi <= addr_a_hi;
            key_reg.addr_a_lo <= addr_a_lo;
            key_reg.addr_b_hi <= addr_b_hi;
            key_reg.addr_b_lo <= addr_b_lo;
            key_reg.port_a    <= port_a;
            key_reg.port_b    <= port_b;
            key_reg.pool_id   <= pool_id;
            key_reg.skip_llb  <= skip_llb;
        end
        if (tok_link[N].vld)
        begin
            end_reg <= tok_link[N];
        end
        if (finish)
        begin
            status_reg   <= status_next;
            hit_reg      <= hit_next;
            slot_reg     <= slot_next;
            hit_id_reg   <= hit_next ? end_reg.hit_id : 16'd0;
            hit_pool_reg <= hit_next ? end_reg.hit_pool : 16'd0;
            hit_kind_reg <= hit_next ? end_reg.hit_kind : 3'd0;
        end
    end

    assign in_stall  = !state_reg[0];
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign hit       = hit_reg;
    assign slot      = slot_reg;
    assign hit_id    = hit_id_reg;
    assign hit_pool  = hit_pool_reg;
    assign hit_kind  = hit_kind_reg;

    `VSRC_ASSERT_ALWAYS(a_hw_bound, !rst_n || (hw_reg <= (IW+1)'(N)), "mark beyond table")
    `VSRC_ASSERT(a_inject, accept |=> tok_link[0].vld, "token not injected")
    `VSRC_ASSERT(a_end_in_scan, tok_link[N].vld |-> (state_reg == ST_SCAN), "token out of scan")
    `VSRC_ASSERT(a_hit_ok, (out_valid && hit) |-> (status == vsrc_pkg::STATUS_OK), "hit not ok")

endmodule
